// ===== design/eaq_pkg.sv =====
// Shared types, constants and helpers for the Euler-angle to quaternion pipeline.
// Used by every module in the design folder; depends on nothing.
package eaq_pkg;

    localparam int ANGLE_BITS     = 16;
    localparam int COMPONENT_BITS = 16;
    localparam int ANGLE_FRAC     = 12;
    localparam int WORK_FRAC      = 28;
    localparam int HALF_SHIFT     = WORK_FRAC - ANGLE_FRAC - 1;
    localparam int WORK_BITS      = 32;
    localparam int PROD_BITS      = 64;
    localparam int CORDIC_STEPS   = 28;

    localparam logic signed [WORK_BITS-1:0] CORDIC_GAIN = 32'sd163008219;
    localparam longint PI_Q28      = 64'd843314857;
    localparam longint HALF_PI_Q28 = PI_Q28 / 2;

    // Quotient bits of the range reduction: |half angle| / pi stays below 2**QUOT_BITS
    localparam int QUOT_BITS = (ANGLE_BITS > 16) ? (ANGLE_BITS - 15) : 1;

    localparam int REDUCE_LAT = QUOT_BITS + 2;
    localparam int CORDIC_LAT = CORDIC_STEPS + 1;
    localparam int QMUL_LAT   = 5;
    localparam int LATENCY    = REDUCE_LAT + CORDIC_LAT + QMUL_LAT;

    localparam int LANES = 3;

    typedef struct packed {
        logic signed [ANGLE_BITS-1:0] angle_x;
        logic signed [ANGLE_BITS-1:0] angle_y;
        logic signed [ANGLE_BITS-1:0] angle_z;
    } angles_t;

    typedef struct packed {
        logic signed [COMPONENT_BITS-1:0] quat_x;
        logic signed [COMPONENT_BITS-1:0] quat_y;
        logic signed [COMPONENT_BITS-1:0] quat_z;
        logic signed [COMPONENT_BITS-1:0] quat_w;
    } quat_t;

    // Reduced half angle and the odd-multiple-of-pi flag
    typedef struct packed {
        logic signed [WORK_BITS-1:0] z;
        logic                        flip;
    } lane_t;

    typedef struct packed {
        logic signed [WORK_BITS-1:0] sin;
        logic signed [WORK_BITS-1:0] cos;
    } sc_t;

    // Arctangent table entry, Q.28, rounded to nearest
    function automatic logic signed [WORK_BITS-1:0] atan_q28(input int i);
        real v;
        v = $atan(2.0 ** (-i)) * 268435456.0;
        return WORK_BITS'($rtoi(v + 0.5));
    endfunction

    // Round a Q.56 product sum to Q.28
    function automatic logic signed [WORK_BITS-1:0] round_q28(
        input logic signed [PROD_BITS-1:0] v
    );
        logic signed [PROD_BITS-1:0] t;
        t = v + (64'sd1 <<< (WORK_FRAC - 1));
        return t[WORK_FRAC+WORK_BITS-1:WORK_FRAC];
    endfunction

endpackage

// ===== design/euler_angles_to_quaternion.sv =====
// Euler angles (x, y, z) to unit quaternion qz*qy*qx, fully pipelined.
// Depends on eaq_pkg, eaq_reduce, eaq_cordic and eaq_qmul.
//
//   channel   strobe        payload                      direction
//   item in   start / busy  angles (angle_x/_y/_z)       into block
//   result    done          quat (quat_x/_y/_z/_w)       out of block
//
// One item is taken every cycle; busy never rises.
// The path is registered through the range reduction, the 28-stage CORDIC and the
// two multiplier stages.
// Reset clears the valid bits only; the data path holds whatever it had.
// The receiver cannot stall, so done is a one-cycle pulse per item.
module euler_angles_to_quaternion (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  eaq_pkg::angles_t angles,
    output logic             done,
    output eaq_pkg::quat_t   quat
);

    logic            red_valid;
    eaq_pkg::lane_t  lane [0:eaq_pkg::LANES-1];
    logic            cor_valid;
    eaq_pkg::sc_t    sc   [0:eaq_pkg::LANES-1];

    assign busy = 1'b0;

    eaq_reduce u_reduce (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start & ~busy),
        .angles    (angles),
        .out_valid (red_valid),
        .lane      (lane)
    );

    eaq_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (red_valid),
        .lane      (lane),
        .out_valid (cor_valid),
        .sc        (sc)
    );

    eaq_qmul u_qmul (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cor_valid),
        .sc       (sc),
        .done     (done),
        .quat     (quat)
    );

    localparam logic signed [eaq_pkg::COMPONENT_BITS-1:0] QONE =
        eaq_pkg::COMPONENT_BITS'(1) <<< (eaq_pkg::COMPONENT_BITS - 2);

    a_done_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, eaq_pkg::LATENCY))
        else $error("result without an item entering the pipeline");

    a_w_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (quat.quat_w <= QONE) && (quat.quat_w >= -QONE))
        else $error("scalar component beyond one");

    a_x_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (quat.quat_x <= QONE) && (quat.quat_x >= -QONE))
        else $error("x component beyond one");

endmodule

// ===== design/eaq_reduce.sv =====
// Range reduction of the three half angles modulo pi, one quotient bit per stage.
// Depends on eaq_pkg.
module eaq_reduce (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  eaq_pkg::angles_t   angles,
    output logic               out_valid,
    output eaq_pkg::lane_t     lane [0:eaq_pkg::LANES-1]
);

    localparam int HW = eaq_pkg::ANGLE_BITS + eaq_pkg::HALF_SHIFT;
    localparam int MW = ((HW > 31) ? HW : 31) + 1;
    localparam int QB = eaq_pkg::QUOT_BITS;
    localparam int NL = eaq_pkg::LANES;
    localparam logic [MW-1:0] PI_M   = MW'(eaq_pkg::PI_Q28);
    localparam logic [MW-1:0] HALF_M = MW'(eaq_pkg::HALF_PI_Q28);

    logic          valid_reg [0:QB];
    logic [MW-1:0] mag_reg   [0:QB][0:NL-1];
    logic          sgn_reg   [0:QB][0:NL-1];
    logic          par_reg   [0:QB][0:NL-1];
    logic          out_valid_reg;
    eaq_pkg::lane_t lane_reg [0:NL-1];

    logic signed [eaq_pkg::ANGLE_BITS-1:0] raw [0:NL-1];
    assign raw[0] = angles.angle_x;
    assign raw[1] = angles.angle_y;
    assign raw[2] = angles.angle_z;

    // Entry: magnitude and sign of the half angle in Q.28
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < NL; l++)
        begin
            logic signed [MW-1:0] h;
            h = MW'(raw[l]) <<< eaq_pkg::HALF_SHIFT;
            sgn_reg[0][l] <= raw[l][eaq_pkg::ANGLE_BITS-1];
            mag_reg[0][l] <= raw[l][eaq_pkg::ANGLE_BITS-1] ? MW'(-h) : MW'(h);
            par_reg[0][l] <= 1'b0;
        end
    end

    genvar j;
    generate
        for (j = 0; j < QB; j++)
        begin : g_div
            localparam logic [MW-1:0] DIV = PI_M << (QB - 1 - j);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[j+1] <= 1'b0;
                end
                else
                begin
                    valid_reg[j+1] <= valid_reg[j];
                end
            end

            always_ff @(posedge clk)
            begin
                for (int l = 0; l < NL; l++)
                begin
                    sgn_reg[j+1][l] <= sgn_reg[j][l];
                    if (mag_reg[j][l] >= DIV)
                    begin
                        mag_reg[j+1][l] <= mag_reg[j][l] - DIV;
                        par_reg[j+1][l] <= 1'b1;
                    end
                    else
                    begin
                        mag_reg[j+1][l] <= mag_reg[j][l];
                        par_reg[j+1][l] <= 1'b0;
                    end
                end
            end
        end
    endgenerate

    // Fold the remainder into [-pi/2, pi/2] and restore the sign
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= valid_reg[QB];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < NL; l++)
        begin
            logic          over;
            logic [MW-1:0] mf;
            over = mag_reg[QB][l] > HALF_M;
            mf   = over ? (mag_reg[QB][l] - PI_M) : mag_reg[QB][l];
            lane_reg[l].z    <= sgn_reg[QB][l] ? eaq_pkg::WORK_BITS'(-mf)
                                               : eaq_pkg::WORK_BITS'(mf);
            lane_reg[l].flip <= par_reg[QB][l] ^ over;
        end
    end

    assign out_valid = out_valid_reg;
    assign lane      = lane_reg;

endmodule

// ===== design/eaq_cordic.sv =====
// Rotation-mode CORDIC, one iteration per register stage, three lanes side by side.
// Depends on eaq_pkg.
module eaq_cordic (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  eaq_pkg::lane_t lane [0:eaq_pkg::LANES-1],
    output logic           out_valid,
    output eaq_pkg::sc_t   sc   [0:eaq_pkg::LANES-1]
);

    localparam int W  = eaq_pkg::WORK_BITS;
    localparam int NS = eaq_pkg::CORDIC_STEPS;
    localparam int NL = eaq_pkg::LANES;

    logic          valid_reg [0:NS];
    logic signed [W-1:0] x_reg [0:NS][0:NL-1];
    logic signed [W-1:0] y_reg [0:NS][0:NL-1];
    logic signed [W-1:0] z_reg [0:NS][0:NL-1];
    logic                f_reg [0:NS][0:NL-1];
    logic          out_valid_reg;
    eaq_pkg::sc_t  sc_reg [0:NL-1];

    // Stage zero holds the start vector
    always_comb
    begin
        valid_reg[0] = in_valid;
        for (int l = 0; l < NL; l++)
        begin
            x_reg[0][l] = eaq_pkg::CORDIC_GAIN;
            y_reg[0][l] = '0;
            z_reg[0][l] = lane[l].z;
            f_reg[0][l] = lane[l].flip;
        end
    end

    genvar i;
    generate
        for (i = 0; i < NS; i++)
        begin : g_step
            localparam logic signed [W-1:0] ATAN = eaq_pkg::atan_q28(i);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[i+1] <= 1'b0;
                end
                else
                begin
                    valid_reg[i+1] <= valid_reg[i];
                end
            end

            always_ff @(posedge clk)
            begin
                for (int l = 0; l < NL; l++)
                begin
                    f_reg[i+1][l] <= f_reg[i][l];
                    if (!z_reg[i][l][W-1])
                    begin
                        x_reg[i+1][l] <= x_reg[i][l] - (y_reg[i][l] >>> i);
                        y_reg[i+1][l] <= y_reg[i][l] + (x_reg[i][l] >>> i);
                        z_reg[i+1][l] <= z_reg[i][l] - ATAN;
                    end
                    else
                    begin
                        x_reg[i+1][l] <= x_reg[i][l] + (y_reg[i][l] >>> i);
                        y_reg[i+1][l] <= y_reg[i][l] - (x_reg[i][l] >>> i);
                        z_reg[i+1][l] <= z_reg[i][l] + ATAN;
                    end
                end
            end
        end
    endgenerate

    // Negate both for an odd multiple of pi
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= valid_reg[NS];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < NL; l++)
        begin
            sc_reg[l].cos <= f_reg[NS][l] ? -x_reg[NS][l] : x_reg[NS][l];
            sc_reg[l].sin <= f_reg[NS][l] ? -y_reg[NS][l] : y_reg[NS][l];
        end
    end

    assign out_valid = out_valid_reg;
    assign sc        = sc_reg;

endmodule

// ===== design/eaq_qmul.sv =====
// Two quaternion products (qz*qy*qx) and the rounding to output components.
// Depends on eaq_pkg.
module eaq_qmul (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  eaq_pkg::sc_t   sc [0:eaq_pkg::LANES-1],
    output logic           done,
    output eaq_pkg::quat_t quat
);

    localparam int W    = eaq_pkg::WORK_BITS;
    localparam int P    = eaq_pkg::PROD_BITS;
    localparam int CB   = eaq_pkg::COMPONENT_BITS;
    localparam int FRAC = CB - 2;
    localparam logic signed [P-1:0] ONE = 64'sd1 <<< FRAC;

    logic [eaq_pkg::QMUL_LAT-1:0] valid_reg;

    logic signed [P-1:0] p1_reg [0:3];
    logic signed [W-1:0] a_reg  [0:3];
    logic signed [P-1:0] p2_reg [0:7];
    logic signed [W-1:0] q_reg  [0:3];
    eaq_pkg::sc_t        z1_reg;
    eaq_pkg::sc_t        z2_reg;
    eaq_pkg::quat_t      quat_reg;
    logic signed [CB-1:0] comp [0:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[eaq_pkg::QMUL_LAT-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        // First product: qy*qx
        p1_reg[0] <= P'(sc[1].cos) * P'(sc[0].sin);
        p1_reg[1] <= P'(sc[1].sin) * P'(sc[0].cos);
        p1_reg[2] <= P'(sc[1].sin) * P'(sc[0].sin);
        p1_reg[3] <= P'(sc[1].cos) * P'(sc[0].cos);
        z1_reg    <= sc[2];

        a_reg[0] <= eaq_pkg::round_q28(p1_reg[0]);
        a_reg[1] <= eaq_pkg::round_q28(p1_reg[1]);
        a_reg[2] <= eaq_pkg::round_q28(-p1_reg[2]);
        a_reg[3] <= eaq_pkg::round_q28(p1_reg[3]);
        z2_reg   <= z1_reg;

        // Second product: qz*(qy*qx)
        p2_reg[0] <= P'(z2_reg.cos) * P'(a_reg[0]);
        p2_reg[1] <= P'(z2_reg.sin) * P'(a_reg[1]);
        p2_reg[2] <= P'(z2_reg.sin) * P'(a_reg[0]);
        p2_reg[3] <= P'(z2_reg.cos) * P'(a_reg[1]);
        p2_reg[4] <= P'(z2_reg.sin) * P'(a_reg[3]);
        p2_reg[5] <= P'(z2_reg.cos) * P'(a_reg[2]);
        p2_reg[6] <= P'(z2_reg.cos) * P'(a_reg[3]);
        p2_reg[7] <= P'(z2_reg.sin) * P'(a_reg[2]);

        q_reg[0] <= eaq_pkg::round_q28(p2_reg[0] - p2_reg[1]);
        q_reg[1] <= eaq_pkg::round_q28(p2_reg[2] + p2_reg[3]);
        q_reg[2] <= eaq_pkg::round_q28(p2_reg[4] + p2_reg[5]);
        q_reg[3] <= eaq_pkg::round_q28(p2_reg[6] - p2_reg[7]);

        quat_reg.quat_x <= comp[0];
        quat_reg.quat_y <= comp[1];
        quat_reg.quat_z <= comp[2];
        quat_reg.quat_w <= comp[3];
    end

    // Round Q.28 to the output format, then clamp to plus or minus one
    genvar c;
    generate
        for (c = 0; c < 4; c++)
        begin : g_comp
            logic signed [P-1:0] r;
            if (FRAC < eaq_pkg::WORK_FRAC)
            begin : g_round
                localparam int SH = eaq_pkg::WORK_FRAC - FRAC;
                assign r = (P'(q_reg[c]) + (64'sd1 <<< (SH - 1))) >>> SH;
            end
            else
            begin : g_scale
                localparam int SH = FRAC - eaq_pkg::WORK_FRAC;
                assign r = P'(q_reg[c]) <<< SH;
            end

            always_comb
            begin
                priority if (r > ONE)
                begin
                    comp[c] = CB'(ONE);
                end
                else if (r < -ONE)
                begin
                    comp[c] = CB'(-ONE);
                end
                else
                begin
                    comp[c] = r[CB-1:0];
                end
            end
        end
    endgenerate

    assign done = valid_reg[eaq_pkg::QMUL_LAT-1];
    assign quat = quat_reg;

endmodule

// ===== test/testbench.sv =====
// Self-checking bench for euler_angles_to_quaternion: a directed table, then random angles.
// Holds its own bit-exact predictor (CORDIC, reduction, products); depends on eaq_pkg.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  NSTEPS      = 28;
    localparam int  CYCLE_LIMIT = 400000;
    localparam int  DRAIN       = eaq_pkg::LATENCY + 10;
    localparam int  AB          = eaq_pkg::ANGLE_BITS;
    localparam int  CB          = eaq_pkg::COMPONENT_BITS;
    localparam int  WF          = eaq_pkg::WORK_FRAC;

    typedef longint q4_t [4];

    typedef struct {
        eaq_pkg::angles_t a;
        bit               typed;
        eaq_pkg::quat_t   q;
    } row_t;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    eaq_pkg::angles_t angles;
    logic             done;
    eaq_pkg::quat_t   quat;

    longint           atan_q [NSTEPS];
    longint           pi_q;
    eaq_pkg::quat_t   quat_due [$];
    int               errors;
    int               taken;
    int               cycles;
    int               idle_pct;

    euler_angles_to_quaternion uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .angles (angles),
        .done   (done),
        .quat   (quat)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Alternating arctangent series in Q.60
    function automatic longint unsigned atan_sum(longint unsigned p, int sh,
                                                 longint unsigned dv);
        longint unsigned sum;
        longint unsigned k;
        longint unsigned t;
        sum = 0;
        k = 0;
        while (p != 0)
        begin
            t = p / (2 * k + 1);
            if (k[0])
                sum = sum - t;
            else
                sum = sum + t;
            k++;
            if (dv != 0)
                p = p / dv;
            else
                p = p >> sh;
        end
        return sum;
    endfunction

    function automatic longint q60_q28(longint unsigned v);
        return longint'((v + (64'd1 << 31)) >> 32);
    endfunction

    function automatic longint rnd_shift(longint v, int s);
        if (s == 0)
            return v;
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    task automatic fill_atan();
        longint unsigned half;
        longint unsigned third;
        half  = atan_sum(64'd1 << 59, 2, 0);
        third = atan_sum((64'd1 << 60) / 3, 0, 9);
        atan_q[0] = q60_q28(half + third);
        for (int i = 1; i < NSTEPS; i++)
            atan_q[i] = q60_q28(atan_sum(64'd1 << (60 - i), 2 * i, 0));
        pi_q = q60_q28(4 * (half + third));
    endtask

    // Half-angle sine on the given axis, cosine in w, Q.28
    function automatic q4_t axis_rot(int axis, logic signed [AB-1:0] raw);
        q4_t    q;
        longint h, k, r, hp, x, y, z, xs, ys;
        h  = longint'(raw) * (64'sd1 <<< (WF - eaq_pkg::ANGLE_FRAC - 1));
        k  = h / pi_q;
        r  = h - k * pi_q;
        hp = pi_q / 2;
        if (r > hp)
        begin
            r = r - pi_q;
            k++;
        end
        if (r < -hp)
        begin
            r = r + pi_q;
            k--;
        end
        x = 163008219;
        y = 0;
        z = r;
        for (int i = 0; i < NSTEPS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x = x - ys;
                y = y + xs;
                z = z - atan_q[i];
            end
            else
            begin
                x = x + ys;
                y = y - xs;
                z = z + atan_q[i];
            end
        end
        if (k[0])
        begin
            x = -x;
            y = -y;
        end
        q = '{0, 0, 0, 0};
        q[axis] = y;
        q[3] = x;
        return q;
    endfunction

    // b*a, rounded back to Q.28
    function automatic q4_t rot_mul(q4_t a, q4_t b);
        q4_t t;
        t[0] = b[0] * a[3] + b[3] * a[0] - b[2] * a[1] + b[1] * a[2];
        t[1] = b[1] * a[3] + b[2] * a[0] + b[3] * a[1] - b[0] * a[2];
        t[2] = b[2] * a[3] - b[1] * a[0] + b[0] * a[1] + b[3] * a[2];
        t[3] = b[3] * a[3] - b[0] * a[0] - b[1] * a[1] - b[2] * a[2];
        for (int j = 0; j < 4; j++)
            t[j] = rnd_shift(t[j], WF);
        return t;
    endfunction

    function automatic logic signed [CB-1:0] to_q14(longint v);
        longint r;
        longint one;
        one = 64'sd1 <<< (CB - 2);
        r = rnd_shift(v, WF - (CB - 2));
        if (r > one)
            r = one;
        if (r < -one)
            r = -one;
        return r[CB-1:0];
    endfunction

    function automatic eaq_pkg::quat_t attitude(eaq_pkg::angles_t a);
        q4_t            q;
        eaq_pkg::quat_t o;
        q = rot_mul(axis_rot(0, a.angle_x), axis_rot(1, a.angle_y));
        q = rot_mul(q, axis_rot(2, a.angle_z));
        o.quat_x = to_q14(q[0]);
        o.quat_y = to_q14(q[1]);
        o.quat_z = to_q14(q[2]);
        o.quat_w = to_q14(q[3]);
        return o;
    endfunction

    // Log accepted items and check results; values read here are pre-edge
    always @(posedge clk)
    begin
        cycles++;
        if (rst_n && start && !busy)
            taken++;
        if (rst_n && done)
        begin
            if (quat_due.size() == 0)
            begin
                $error("result with nothing expected: %h", quat);
                errors++;
            end
            else
            begin
                eaq_pkg::quat_t e;
                e = quat_due.pop_front();
                if (quat.quat_x !== e.quat_x)
                begin
                    $error("quat_x expected %0d got %0d", e.quat_x, quat.quat_x);
                    errors++;
                end
                if (quat.quat_y !== e.quat_y)
                begin
                    $error("quat_y expected %0d got %0d", e.quat_y, quat.quat_y);
                    errors++;
                end
                if (quat.quat_z !== e.quat_z)
                begin
                    $error("quat_z expected %0d got %0d", e.quat_z, quat.quat_z);
                    errors++;
                end
                if (quat.quat_w !== e.quat_w)
                begin
                    $error("quat_w expected %0d got %0d", e.quat_w, quat.quat_w);
                    errors++;
                end
            end
        end
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL euler_angles_to_quaternion");
            $finish;
        end
    end

    // Present one item from the falling edge, idling first at random
    task automatic send_item(eaq_pkg::angles_t a, eaq_pkg::quat_t e);
        int seen;
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start  <= 1'b1;
        angles <= a;
        quat_due.push_back(e);
        seen = taken;
        do
            @(negedge clk);
        while (taken == seen);
    endtask

    task automatic wait_empty();
        start <= 1'b0;
        @(negedge clk);
        while (quat_due.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic signed [AB-1:0] pick_angle();
        case ($urandom_range(5))
            0:       return AB'(16'sh7fff - $urandom_range(3));
            1:       return AB'(16'sh8000 + $urandom_range(3));
            2:       return AB'($urandom_range(300) - 150);
            3:       return AB'(12868 * ($urandom_range(10) - 5) + $urandom_range(4) - 2);
            default: return AB'($urandom);
        endcase
    endfunction

    row_t rows [$];

    function automatic row_t mk(int x, int y, int z);
        row_t r;
        r.a.angle_x = AB'(x);
        r.a.angle_y = AB'(y);
        r.a.angle_z = AB'(z);
        r.typed = 1'b0;
        r.q = '0;
        return r;
    endfunction

    initial
    begin
        int               pct [4];
        row_t             r;
        eaq_pkg::quat_t   e;
        eaq_pkg::angles_t a;
        pct = '{0, 85, 0, 33};
        errors = 0;
        taken = 0;
        cycles = 0;
        idle_pct = 0;
        rst_n = 1'b0;
        start = 1'b0;
        angles = '0;
        fill_atan();

        // Zero rotation gives the identity quaternion
        r = mk(0, 0, 0);
        r.typed = 1'b1;
        r.q = '{quat_x: 0, quat_y: 0, quat_z: 0, quat_w: 16384};
        rows.push_back(r);
        rows.push_back(mk(32767, 0, 0));
        rows.push_back(mk(-32768, 0, 0));
        rows.push_back(mk(0, 32767, 0));
        rows.push_back(mk(0, -32768, 0));
        rows.push_back(mk(0, 0, 32767));
        rows.push_back(mk(0, 0, -32768));
        rows.push_back(mk(32767, 32767, 32767));
        rows.push_back(mk(-32768, -32768, -32768));
        rows.push_back(mk(12868, 0, 0));
        rows.push_back(mk(-12868, 0, 0));
        rows.push_back(mk(6434, 6434, 6434));
        rows.push_back(mk(25736, -25736, 12868));
        rows.push_back(mk(1, -1, 1));
        rows.push_back(mk(6433, 6435, -6434));
        rows.push_back(mk(19302, 19303, -19302));
        rows.push_back(mk(4096, 8192, -4096));
        rows.push_back(mk(-1, 0, 32767));

        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (rows[i])
        begin
            e = rows[i].typed ? rows[i].q : attitude(rows[i].a);
            send_item(rows[i].a, e);
        end
        // Hold off until the pipeline has emptied
        wait_empty();

        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct = pct[ph];
            for (int n = 0; n < 410; n++)
            begin
                a.angle_x = pick_angle();
                a.angle_y = pick_angle();
                a.angle_z = pick_angle();
                send_item(a, attitude(a));
            end
            wait_empty();
        end

        repeat (DRAIN) @(posedge clk);
        if (errors == 0 && quat_due.size() == 0)
            $display("PASS euler_angles_to_quaternion");
        else
            $display("FAIL euler_angles_to_quaternion");
        $finish;
    end
endmodule
